FILE: hdl/trrp_pkg.sv
package trrp_pkg;

    localparam int unsigned SeqW       = 32;
    localparam int unsigned LenW       = 16;
    localparam int unsigned MssW       = 15;
    localparam int unsigned TisW       = 24;
    localparam int unsigned KeyW       = 32;
    localparam int unsigned IdxW       = 64;
    localparam int unsigned AddrW      = 64;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 32;
    localparam int unsigned RemW       = 16;
    localparam int unsigned SpanLimW   = 20;

    localparam logic [SeqW-1:0] MaxRecordSpan = SeqW'(16413);
    localparam logic [MssW-1:0] MssMin        = MssW'(536);
    localparam logic [MssW-1:0] MssMax        = MssW'(16384);
    localparam logic [MssW-1:0] MssReset      = MssW'(1460);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OFFLOAD_EN = 3'd0,
        CFG_START_SEQ  = 3'd1,
        CFG_MSS        = 3'd2,
        CFG_TIS        = 3'd3,
        CFG_KEY        = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_SETUP   = 2'd1,
        KIND_FENCE   = 2'd2,
        KIND_DUMP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FENCE,
        ST_DUMP,
        ST_VERDICT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  dump_step;
        t_kind kind;
    } t_ctrl_cmd;

    typedef struct packed {
        logic act;
        logic resync;
        logic span;
        logic gap_zero;
        logic last_dump;
    } t_dp_status;

endpackage

FILE: hdl/tls_tx_resync_replay_planner.sv
// TLS transmit resync planner: takes one segment descriptor per input transaction and
// emits a run of result transactions ending in a verdict (o_last high). An in-order or
// unhandled segment is accepted in ST_IDLE and its verdict presented from ST_VERDICT. A
// resync adds a context setup and, unless the span check fails, a fence or replay dumps
// (up to 31) before the verdict, each dump stepped by a single 64-bit address adder and
// a remainder subtractor. One segment is in flight at a time; configuration writes must
// be issued only while the block is idle.
module tls_tx_resync_replay_planner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [trrp_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [trrp_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [trrp_pkg::SeqW-1:0]         i_seg_seqno,
    input  logic [trrp_pkg::LenW-1:0]         i_seg_len,
    input  logic                              i_is_zerocopy,
    input  logic [trrp_pkg::SeqW-1:0]         i_record_start_seqno,
    input  logic [trrp_pkg::IdxW-1:0]         i_record_index,
    input  logic [trrp_pkg::AddrW-1:0]        i_record_base_addr,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic                              o_tag_valid,
    output logic [trrp_pkg::TisW-1:0]         o_tag_tis,
    output logic [trrp_pkg::KeyW-1:0]         o_setup_key,
    output logic [trrp_pkg::IdxW-1:0]         o_setup_record_index,
    output logic [trrp_pkg::SeqW-1:0]         o_setup_seqno,
    output logic [trrp_pkg::AddrW-1:0]        o_dump_addr,
    output logic [trrp_pkg::MssW-1:0]         o_dump_len,
    output logic                              o_span_error,
    output logic                              o_last
);

    trrp_pkg::t_ctrl_cmd  cmd;
    trrp_pkg::t_dp_status status;

    // writes only land while idle and no segment is being taken
    assign o_cfg_ready = o_ready && !i_valid;

    trrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    trrp_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_seg_seqno          (i_seg_seqno),
        .i_seg_len            (i_seg_len),
        .i_is_zerocopy        (i_is_zerocopy),
        .i_record_start_seqno (i_record_start_seqno),
        .i_record_index       (i_record_index),
        .i_record_base_addr   (i_record_base_addr),
        .i_cmd                (cmd),
        .o_status             (status),
        .o_kind               (o_kind),
        .o_tag_valid          (o_tag_valid),
        .o_tag_tis            (o_tag_tis),
        .o_setup_key          (o_setup_key),
        .o_setup_record_index (o_setup_record_index),
        .o_setup_seqno        (o_setup_seqno),
        .o_dump_addr          (o_dump_addr),
        .o_dump_len           (o_dump_len),
        .o_span_error         (o_span_error),
        .o_last               (o_last)
    );

endmodule

FILE: hdl/trrp_ctrl.sv
module trrp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  trrp_pkg::t_dp_status i_status,
    output trrp_pkg::t_ctrl_cmd  o_cmd
);

    trrp_pkg::t_state r_state;
    trrp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trrp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        o_valid         = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.dump_step = 1'b0;
        o_cmd.kind      = trrp_pkg::KIND_VERDICT;
        unique case (r_state)
            trrp_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    if (i_status.act && i_status.resync) begin
                        n_state = trrp_pkg::ST_SETUP;
                    end else begin
                        n_state = trrp_pkg::ST_VERDICT;
                    end
                end
            end
            trrp_pkg::ST_SETUP: begin
                o_valid    = 1'b1;
                o_cmd.kind = trrp_pkg::KIND_SETUP;
                if (i_ready) begin
                    priority if (i_status.span) begin
                        n_state = trrp_pkg::ST_VERDICT;
                    end else if (i_status.gap_zero) begin
                        n_state = trrp_pkg::ST_FENCE;
                    end else begin
                        n_state = trrp_pkg::ST_DUMP;
                    end
                end
            end
            trrp_pkg::ST_FENCE: begin
                o_valid    = 1'b1;
                o_cmd.kind = trrp_pkg::KIND_FENCE;
                if (i_ready) begin
                    n_state = trrp_pkg::ST_VERDICT;
                end
            end
            trrp_pkg::ST_DUMP: begin
                o_valid         = 1'b1;
                o_cmd.kind      = trrp_pkg::KIND_DUMP;
                o_cmd.dump_step = i_ready;
                if (i_ready && i_status.last_dump) begin
                    n_state = trrp_pkg::ST_VERDICT;
                end
            end
            trrp_pkg::ST_VERDICT: begin
                o_valid    = 1'b1;
                o_cmd.kind = trrp_pkg::KIND_VERDICT;
                if (i_ready) begin
                    n_state = trrp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = trrp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/trrp_dp.sv
module trrp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [trrp_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [trrp_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic [trrp_pkg::SeqW-1:0]         i_seg_seqno,
    input  logic [trrp_pkg::LenW-1:0]         i_seg_len,
    input  logic                              i_is_zerocopy,
    input  logic [trrp_pkg::SeqW-1:0]         i_record_start_seqno,
    input  logic [trrp_pkg::IdxW-1:0]         i_record_index,
    input  logic [trrp_pkg::AddrW-1:0]        i_record_base_addr,
    input  trrp_pkg::t_ctrl_cmd               i_cmd,
    output trrp_pkg::t_dp_status              o_status,
    output logic [1:0]                        o_kind,
    output logic                              o_tag_valid,
    output logic [trrp_pkg::TisW-1:0]         o_tag_tis,
    output logic [trrp_pkg::KeyW-1:0]         o_setup_key,
    output logic [trrp_pkg::IdxW-1:0]         o_setup_record_index,
    output logic [trrp_pkg::SeqW-1:0]         o_setup_seqno,
    output logic [trrp_pkg::AddrW-1:0]        o_dump_addr,
    output logic [trrp_pkg::MssW-1:0]         o_dump_len,
    output logic                              o_span_error,
    output logic                              o_last
);

    // configuration registers
    logic                          r_enabled;
    logic [trrp_pkg::SeqW-1:0]     r_start_seqno;
    logic [trrp_pkg::MssW-1:0]     r_mss;
    logic [trrp_pkg::TisW-1:0]     r_tis;
    logic [trrp_pkg::KeyW-1:0]     r_key;
    logic [trrp_pkg::SeqW-1:0]     r_expected;

    // per segment
    logic                          r_act;
    logic                          r_resync;
    logic [trrp_pkg::SeqW-1:0]     r_gap;
    logic [trrp_pkg::RemW-1:0]     r_rem;
    logic [trrp_pkg::IdxW-1:0]     r_rec_idx;
    logic [trrp_pkg::SeqW-1:0]     r_rec_seq;
    logic [trrp_pkg::AddrW-1:0]    r_addr;

    logic [trrp_pkg::MssW-1:0]     mss_eff;
    logic [trrp_pkg::SpanLimW-1:0] dump_lim;
    logic                          act;
    logic                          span;
    logic [trrp_pkg::RemW-1:0]     mss_rem;

    always_comb begin
        priority if (r_mss < trrp_pkg::MssMin) begin
            mss_eff = trrp_pkg::MssMin;
        end else if (r_mss > trrp_pkg::MssMax) begin
            mss_eff = trrp_pkg::MssMax;
        end else begin
            mss_eff = r_mss;
        end
    end

    // at most 31 dumps of mss bytes each
    assign dump_lim = {mss_eff, 5'b0} - trrp_pkg::SpanLimW'(mss_eff);
    assign mss_rem  = trrp_pkg::RemW'(mss_eff);
    assign act      = r_enabled && i_is_zerocopy && (i_seg_len != '0);
    assign span     = (r_gap > trrp_pkg::MaxRecordSpan)
                   || (r_gap > trrp_pkg::SeqW'(dump_lim));

    assign o_status.act       = act;
    assign o_status.resync    = (i_seg_seqno != r_expected);
    assign o_status.span      = span;
    assign o_status.gap_zero  = (r_gap == '0);
    assign o_status.last_dump = (r_rem <= mss_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_start_seqno <= '0;
            r_mss         <= trrp_pkg::MssReset;
            r_tis         <= '0;
            r_key         <= '0;
            r_expected    <= '0;
            r_act         <= 1'b0;
            r_resync      <= 1'b0;
        end else if (i_cmd.load) begin
            r_act    <= act;
            r_resync <= act && (i_seg_seqno != r_expected);
            if (act) begin
                r_expected <= i_seg_seqno + trrp_pkg::SeqW'(i_seg_len);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                trrp_pkg::CFG_OFFLOAD_EN: begin
                    r_enabled <= i_cfg_data[0];
                    if (i_cfg_data[0]) begin
                        r_expected <= r_start_seqno;
                    end
                end
                trrp_pkg::CFG_START_SEQ: r_start_seqno <= i_cfg_data;
                trrp_pkg::CFG_MSS:       r_mss <= i_cfg_data[trrp_pkg::MssW-1:0];
                trrp_pkg::CFG_TIS:       r_tis <= i_cfg_data[trrp_pkg::TisW-1:0];
                trrp_pkg::CFG_KEY:       r_key <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gap     <= i_seg_seqno - i_record_start_seqno;
            r_rem     <= trrp_pkg::RemW'(i_seg_seqno - i_record_start_seqno);
            r_rec_idx <= i_record_index;
            r_rec_seq <= i_record_start_seqno;
            r_addr    <= i_record_base_addr;
        end else if (i_cmd.dump_step) begin
            r_rem  <= r_rem - mss_rem;
            r_addr <= r_addr + trrp_pkg::AddrW'(mss_eff);
        end
    end

    always_comb begin
        o_kind               = i_cmd.kind;
        o_tag_valid          = 1'b0;
        o_tag_tis            = '0;
        o_setup_key          = '0;
        o_setup_record_index = '0;
        o_setup_seqno        = '0;
        o_dump_addr          = '0;
        o_dump_len           = '0;
        o_span_error         = 1'b0;
        o_last               = 1'b0;
        unique case (i_cmd.kind)
            trrp_pkg::KIND_VERDICT: begin
                o_last       = 1'b1;
                o_tag_valid  = r_act;
                o_tag_tis    = r_act ? r_tis : '0;
                o_span_error = r_resync && span;
            end
            trrp_pkg::KIND_SETUP: begin
                o_tag_tis            = r_tis;
                o_setup_key          = r_key;
                o_setup_record_index = r_rec_idx;
                o_setup_seqno        = r_rec_seq;
            end
            trrp_pkg::KIND_FENCE: ;
            trrp_pkg::KIND_DUMP: begin
                o_dump_addr = r_addr;
                o_dump_len  = (r_rem > mss_rem) ? mss_eff : r_rem[trrp_pkg::MssW-1:0];
            end
            default: ;
        endcase
    end

endmodule
